### hw/rtl/nsks_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsks_pkg: shared types and constants for the sorted key snap block
// Table geometry, time format, and the item and control structs that pass
// through the top level, or between it and the search sequencer.
// ----------------------------------------------------------------------------
package nsks_pkg;

    // Table geometry.
    localparam int TABLE_DEPTH = 1024;
    localparam int ADDR_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Times are signed fixed point with 16 fraction bits.
    localparam int TIME_W      = 48;
    localparam int DIST_W      = TIME_W + 1;
    localparam int QNUM_W      = 16;

    // Command codes of an input item.
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // One input item.
    typedef struct packed {
        logic                     cmd;
        logic [ADDR_W-1:0]        key_slot;
        logic signed [TIME_W-1:0] time_value;
        logic                     last_query;
    } nsks_in_t;

    // One result item.
    typedef struct packed {
        logic signed [TIME_W-1:0] snapped_time;
        logic [QNUM_W-1:0]        query_number;
    } nsks_out_t;

    // Query request from the top level to the search sequencer.
    typedef struct packed {
        logic                     go;
        logic [CNT_W-1:0]         count;
        logic signed [TIME_W-1:0] target;
    } nsks_req_t;

    // Status and answer from the search sequencer.
    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic signed [TIME_W-1:0] snapped;
    } nsks_rsp_t;

endpackage

### hw/rtl/nsks_key_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsks_key_ram: key table storage
// Simple dual-port memory, one write port and one read port with a
// registered read. Contents are undefined until written.
// ----------------------------------------------------------------------------
module nsks_key_ram (
    input  logic                             clk,
    input  logic                             wr_en,
    input  logic [nsks_pkg::ADDR_W-1:0]      wr_addr,
    input  logic signed [nsks_pkg::TIME_W-1:0] wr_data,
    input  logic [nsks_pkg::ADDR_W-1:0]      rd_addr,
    output logic signed [nsks_pkg::TIME_W-1:0] rd_data
);

    logic signed [nsks_pkg::TIME_W-1:0] mem [nsks_pkg::TABLE_DEPTH];

    // Write port.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port, read every cycle.
    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

### hw/rtl/nsks_dist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsks_dist: shared subtract unit
// Forms the exact signed difference of two times at one extra bit. Its sign
// drives the search compare and its magnitude gives the neighbor distance.
// ----------------------------------------------------------------------------
module nsks_dist (
    input  logic signed [nsks_pkg::TIME_W-1:0] a,
    input  logic signed [nsks_pkg::TIME_W-1:0] b,
    output logic                               lt,
    output logic [nsks_pkg::DIST_W-1:0]        mag
);

    logic [nsks_pkg::DIST_W-1:0] diff;

    // Sign-extended difference a - b; cannot overflow at this width.
    assign diff = {a[nsks_pkg::TIME_W-1], a} - {b[nsks_pkg::TIME_W-1], b};
    assign lt   = diff[nsks_pkg::DIST_W-1];

    // Absolute value; the largest magnitude still fits unsigned.
    assign mag  = lt ? (~diff + nsks_pkg::DIST_W'(1)) : diff;

endmodule

### hw/rtl/nsks_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nsks_seq: binary search sequencer
// Runs a lower-bound search over the key memory, one read per step, then
// fetches the lone neighbor or both neighbors and picks the nearer one
// using the shared subtract unit.
// ----------------------------------------------------------------------------
module nsks_seq (
    input  logic                               clk,
    input  logic                               rst_n,
    input  nsks_pkg::nsks_req_t                req,
    output nsks_pkg::nsks_rsp_t                rsp,
    output logic [nsks_pkg::ADDR_W-1:0]        rd_addr,
    input  logic signed [nsks_pkg::TIME_W-1:0] rd_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SRCH,
        S_NB1,
        S_NB2,
        S_CMP
    } state_t;

    state_t                             state_reg, state_next;
    logic [nsks_pkg::CNT_W-1:0]         lo_reg, lo_next;
    logic [nsks_pkg::CNT_W-1:0]         hi_reg, hi_next;
    logic [nsks_pkg::CNT_W-1:0]         n_reg, n_next;
    logic [nsks_pkg::ADDR_W-1:0]        mid_reg, mid_next;
    logic signed [nsks_pkg::TIME_W-1:0] target_reg, target_next;
    logic signed [nsks_pkg::TIME_W-1:0] up_reg, up_next;
    logic [nsks_pkg::DIST_W-1:0]        up_dist_reg, up_dist_next;
    logic signed [nsks_pkg::TIME_W-1:0] down_reg, down_next;
    logic [nsks_pkg::DIST_W-1:0]        down_dist_reg, down_dist_next;
    logic                               done_reg, done_next;
    logic signed [nsks_pkg::TIME_W-1:0] snapped_reg, snapped_next;

    logic                               key_lt;
    logic [nsks_pkg::DIST_W-1:0]        key_dist;
    logic [nsks_pkg::CNT_W-1:0]         step_lo;
    logic [nsks_pkg::CNT_W-1:0]         step_hi;
    logic [nsks_pkg::CNT_W:0]           step_sum;
    logic [nsks_pkg::CNT_W-1:0]         step_mid;
    logic [nsks_pkg::CNT_W-1:0]         first_nb;
    logic [nsks_pkg::CNT_W-1:0]         lo_dec;
    logic                               two_nb;

    // Shared subtract unit: memory data against the target.
    nsks_dist u_dist (
        .a   (rd_data),
        .b   (target_reg),
        .lt  (key_lt),
        .mag (key_dist)
    );

    // One search step from the key read in the previous cycle.
    always_comb
    begin
        step_lo  = key_lt ? ({1'b0, mid_reg} + nsks_pkg::CNT_W'(1)) : lo_reg;
        step_hi  = key_lt ? hi_reg : {1'b0, mid_reg};
        step_sum = {1'b0, step_lo} + {1'b0, step_hi};
        step_mid = step_sum[nsks_pkg::CNT_W:1];
        first_nb = (step_lo < n_reg) ? step_lo : (step_lo - nsks_pkg::CNT_W'(1));
        lo_dec   = lo_reg - nsks_pkg::CNT_W'(1);
        two_nb   = (lo_reg < n_reg) && (lo_reg != '0);
    end

    // Sequencer next-state logic.
    always_comb
    begin
        state_next     = state_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        n_next         = n_reg;
        mid_next       = mid_reg;
        target_next    = target_reg;
        up_next        = up_reg;
        up_dist_next   = up_dist_reg;
        down_next      = down_reg;
        down_dist_next = down_dist_reg;
        done_next      = 1'b0;
        snapped_next   = snapped_reg;
        rd_addr        = mid_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (req.go)
                begin
                    target_next = req.target;
                    n_next      = req.count;
                    if (req.count == '0)
                    begin
                        // Empty table echoes the target.
                        snapped_next = req.target;
                        done_next    = 1'b1;
                    end
                    else
                    begin
                        lo_next    = '0;
                        hi_next    = req.count;
                        mid_next   = req.count[nsks_pkg::CNT_W-1:1];
                        rd_addr    = req.count[nsks_pkg::CNT_W-1:1];
                        state_next = S_SRCH;
                    end
                end
            end

            S_SRCH:
            begin
                lo_next = step_lo;
                hi_next = step_hi;
                if (step_lo < step_hi)
                begin
                    mid_next = step_mid[nsks_pkg::ADDR_W-1:0];
                    rd_addr  = step_mid[nsks_pkg::ADDR_W-1:0];
                end
                else
                begin
                    // Search done: fetch the upper neighbor, or the last key.
                    rd_addr    = first_nb[nsks_pkg::ADDR_W-1:0];
                    state_next = S_NB1;
                end
            end

            S_NB1:
            begin
                if (two_nb)
                begin
                    up_next      = rd_data;
                    up_dist_next = key_dist;
                    rd_addr      = lo_dec[nsks_pkg::ADDR_W-1:0];
                    state_next   = S_NB2;
                end
                else
                begin
                    snapped_next = rd_data;
                    done_next    = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            S_NB2:
            begin
                down_next      = rd_data;
                down_dist_next = key_dist;
                state_next     = S_CMP;
            end

            S_CMP:
            begin
                // A tie goes to the upper neighbor.
                snapped_next = (up_dist_reg <= down_dist_reg) ? up_reg : down_reg;
                done_next    = 1'b1;
                state_next   = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        n_reg         <= n_next;
        mid_reg       <= mid_next;
        target_reg    <= target_next;
        up_reg        <= up_next;
        up_dist_reg   <= up_dist_next;
        down_reg      <= down_next;
        down_dist_reg <= down_dist_next;
        snapped_reg   <= snapped_next;
    end

    assign rsp.busy    = (state_reg != S_IDLE);
    assign rsp.done    = done_reg;
    assign rsp.snapped = snapped_reg;

endmodule

### hw/rtl/nearest_sorted_key_snap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nearest_sorted_key_snap: snap a time to the nearest key in a sorted table
// Keeps up to 1024 ascending key times and answers nearest-key queries.
//
// Usage: present an item on item and raise start; it is taken at a clock
// edge where start is high and busy is low. A write item (cmd = write) stores
// time_value at key_slot and gives no result. A query item runs
// a binary search over the first key_count keys (key_count_we/key_count_wd,
// written while idle, clamped to the table depth).
// Each query gives one result item, shown on result for one cycle with done
// high. The receiver cannot stall; a result must be taken when it appears.
// An empty table answers in the cycle after acceptance. Otherwise a query
// holds busy for its search steps, between floor(log2(n + 1)) and
// ceil(log2(n + 1)) of them, then fetches a lone neighbor, or fetches both
// neighbors and compares them. Each search step is one read of the single
// key memory read port. The result appears in the cycle that busy falls,
// when a new item may already be accepted. Reset clears the key count, the
// query counter and the sequencer; table contents are undefined until
// written.
// ----------------------------------------------------------------------------
module nearest_sorted_key_snap (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  nsks_pkg::nsks_in_t                item,
    output logic                              done,
    output nsks_pkg::nsks_out_t               result,
    input  logic                              key_count_we,
    input  logic [nsks_pkg::CNT_W-1:0]        key_count_wd
);

    logic [nsks_pkg::CNT_W-1:0]         key_count_reg;
    logic [nsks_pkg::QNUM_W-1:0]        qcount_reg, qcount_next;
    logic [nsks_pkg::QNUM_W-1:0]        qnum_reg, qnum_next;
    logic                               accept;
    logic                               query_go;
    logic                               key_wr;
    logic [nsks_pkg::CNT_W-1:0]         count_eff;
    nsks_pkg::nsks_req_t                req;
    nsks_pkg::nsks_rsp_t                rsp;
    logic [nsks_pkg::ADDR_W-1:0]        rd_addr;
    logic signed [nsks_pkg::TIME_W-1:0] rd_data;

    // Item acceptance and decode.
    assign accept   = start && !busy;
    assign query_go = accept && (item.cmd == nsks_pkg::CMD_QUERY);
    assign key_wr   = accept && (item.cmd == nsks_pkg::CMD_WRITE);

    // Key count clamped to the table depth.
    assign count_eff = (key_count_reg > nsks_pkg::CNT_W'(nsks_pkg::TABLE_DEPTH))
                     ? nsks_pkg::CNT_W'(nsks_pkg::TABLE_DEPTH) : key_count_reg;

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg <= '0;
        end
        else if (key_count_we)
        begin
            key_count_reg <= key_count_wd;
        end
    end

    // Query numbering within a batch.
    always_comb
    begin
        qcount_next = qcount_reg;
        qnum_next   = qnum_reg;
        if (query_go)
        begin
            qnum_next   = qcount_reg;
            qcount_next = item.last_query ? '0 : (qcount_reg + nsks_pkg::QNUM_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            qcount_reg <= '0;
        end
        else
        begin
            qcount_reg <= qcount_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qnum_reg <= qnum_next;
    end

    // Key table.
    nsks_key_ram u_ram (
        .clk     (clk),
        .wr_en   (key_wr),
        .wr_addr (item.key_slot),
        .wr_data (item.time_value),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Search sequencer.
    assign req.go     = query_go;
    assign req.count  = count_eff;
    assign req.target = item.time_value;

    nsks_seq u_seq (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req),
        .rsp     (rsp),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    // Outputs.
    assign busy                = rsp.busy;
    assign done                = rsp.done;
    assign result.snapped_time = rsp.snapped;
    assign result.query_number = qnum_reg;

endmodule
